[design/kort_pkg.sv]
package kort_pkg;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int STAMP_W = 64;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
  localparam logic [OP_W-1:0] OP_GET     = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL     = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_OLD = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [STAMP_W-1:0] stamp;
  } rec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

[design/keyed_ordered_record_table_core.sv]
// keyed ordered record table: up to CAPACITY records {key, value, stamp}
// held packed in insertion order in one synchronous record memory.
// input channel: in_valid/in_ready with in_opcode, in_client_key,
// in_payload_value, in_date_stamp; one beat is one operation.
// result channel: out_valid/out_ready, exactly one result beat per operation
// carrying status, found value, found stamp and the entry count after it.
// in_ready is high only while no operation is in progress.
// clear, a bad opcode or any operation on an empty table (a put into an
// empty table writes at index 0) skip the scan; a lookup scans keys from
// index 0 at one memory read a cycle until a match or the last record; a
// delete adds a compaction pass that reads one record and writes back the
// one before it each cycle. the single memory port pair sets this pace.
// the finished result sits in an output register, so a new operation is
// accepted while the previous result waits for out_ready; the block holds
// in its final step if a second result would overwrite an untaken one.
// reset (rst_n low, synchronous) empties the table and drops any pending
// result; the memory itself is not cleared.
module keyed_ordered_record_table_core
  import kort_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_W-1:0]           in_opcode,
  input  logic signed [KEY_W-1:0]   in_client_key,
  input  logic signed [VALUE_W-1:0] in_payload_value,
  input  logic [STAMP_W-1:0]        in_date_stamp,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [VALUE_W-1:0] out_found_value,
  output logic [STAMP_W-1:0]        out_found_stamp,
  output logic [COUNT_W-1:0]        out_entry_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;

  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;

  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic [CW-1:0] chk_idx_r, chk_idx_nxt;
  logic [CW-1:0] total_r, total_nxt;

  logic [STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic [STAMP_W-1:0] res_stamp_r, res_stamp_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [STAMP_W-1:0] out_stamp_r;
  logic [CW-1:0]      out_count_r;

  rec_t          mem_q [CAPACITY];
  rec_t          rdata_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  rec_t          mem_wdata;

  logic accept;
  logic hit;
  logic last;
  logic out_free;
  logic more;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign hit      = chk_v_r && ((op_r == OP_DEL_OLD) || (rdata_r.key == key_r));
  assign last     = chk_v_r && (CW'(chk_idx_r + 1'b1) == total_r);
  assign more     = (ptr_r < total_r);

  // record memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem_q[mem_raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_PUT, OP_GET, OP_DEL, OP_DEL_OLD: begin
              state_nxt = (total_r == '0) ? S_DONE : S_SCAN;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = ((op_r == OP_DEL) || (op_r == OP_DEL_OLD)) ? S_SHIFT : S_DONE;
        end else if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!more && !chk_v_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    stamp_nxt      = stamp_r;
    ptr_nxt        = ptr_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    total_nxt      = total_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_stamp_nxt  = res_stamp_r;
    mem_we         = 1'b0;
    mem_waddr      = chk_idx_r[IW-1:0];
    mem_raddr      = ptr_r[IW-1:0];
    mem_wdata      = '{key: key_r, value: val_r, stamp: stamp_r};
    out_valid_nxt  = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        ptr_nxt = '0;
        if (accept) begin
          op_nxt         = in_opcode;
          key_nxt        = in_client_key;
          val_nxt        = in_payload_value;
          stamp_nxt      = in_date_stamp;
          res_value_nxt  = '0;
          res_stamp_nxt  = '0;
          res_status_nxt = ST_NOT_FOUND;
          case (in_opcode)
            OP_PUT: begin
              if (total_r == '0) begin
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata      = '{key: in_client_key, value: in_payload_value,
                                   stamp: in_date_stamp};
                total_nxt      = CW'(1);
                res_status_nxt = ST_INSERTED;
                res_value_nxt  = in_payload_value;
                res_stamp_nxt  = in_date_stamp;
              end
            end
            OP_GET, OP_DEL, OP_DEL_OLD: begin
              if (total_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end
            end
            OP_CLEAR: begin
              total_nxt      = '0;
              res_status_nxt = ST_OK;
            end
            default: res_status_nxt = ST_NOT_FOUND;
          endcase
        end
      end
      S_SCAN: begin
        if (more) begin
          ptr_nxt     = CW'(ptr_r + 1'b1);
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = ptr_r;
        end
        if (hit) begin
          res_status_nxt = ST_OK;
          res_value_nxt  = rdata_r.value;
          res_stamp_nxt  = rdata_r.stamp;
          chk_v_nxt      = 1'b0;
          case (op_r)
            OP_PUT: begin
              mem_we        = 1'b1;
              mem_waddr     = chk_idx_r[IW-1:0];
              res_value_nxt = val_r;
              res_stamp_nxt = stamp_r;
            end
            OP_DEL, OP_DEL_OLD: begin
              ptr_nxt = CW'(chk_idx_r + 1'b1);
            end
            default: ;
          endcase
        end else if (last) begin
          chk_v_nxt      = 1'b0;
          res_status_nxt = ST_NOT_FOUND;
          if (op_r == OP_PUT) begin
            if (total_r < CW'(CAPACITY)) begin
              mem_we         = 1'b1;
              mem_waddr      = total_r[IW-1:0];
              total_nxt      = CW'(total_r + 1'b1);
              res_status_nxt = ST_INSERTED;
              res_value_nxt  = val_r;
              res_stamp_nxt  = stamp_r;
            end else begin
              res_status_nxt = ST_FULL;
            end
          end
        end
      end
      S_SHIFT: begin
        // read entry i+1, write it back to i on the next cycle
        if (more) begin
          ptr_nxt     = CW'(ptr_r + 1'b1);
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = ptr_r;
        end
        if (chk_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = IW'(chk_idx_r - 1'b1);
          mem_wdata = rdata_r;
        end
        if (!more && !chk_v_r) begin
          total_nxt = CW'(total_r - 1'b1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    stamp_r      <= stamp_nxt;
    ptr_r        <= ptr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_stamp_r  <= res_stamp_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_stamp_r  <= res_stamp_r;
      out_count_r  <= total_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;
  assign out_found_stamp = out_stamp_r;
  assign out_entry_count = COUNT_W'(out_count_r);

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(CAPACITY))
    else $error("record count beyond capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, mem_waddr} <= {1'b0, total_r}))
    else $error("record write beyond the packed region");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second operation accepted while one is in progress");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the final step");
`endif

endmodule
